### design/etf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// etf_pkg
// Shared types and character codes for the terminal escape filter.
// ---------------------------------------------------------------------------
package etf_pkg;

   // tuser on the request side
   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   localparam logic [7:0] CH_BEL       = 8'h07;
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_ESC       = 8'h1B;
   localparam logic [7:0] CH_CSI_OPEN  = 8'h5B;  // '['
   localparam logic [7:0] CH_BSL       = 8'h5C;  // '\'
   localparam logic [7:0] CH_OSC_OPEN  = 8'h5D;  // ']'
   localparam logic [7:0] CSI_FINAL_LO = 8'h40;
   localparam logic [7:0] CSI_FINAL_HI = 8'h7E;

   typedef enum logic [2:0] {
      MODE_TEXT    = 3'd0,
      MODE_ESC     = 3'd1,
      MODE_CSI     = 3'd2,
      MODE_OSC     = 3'd3,
      MODE_OSC_ESC = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ERASE = 2'd1,
      ST_DRAIN = 2'd2
   } ctl_state_type;

   // what the parser wants done with the current byte
   typedef struct packed {
      logic push;
      logic erase;
   } parse_act_type;

endpackage

### design/etf_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// etf_parser
// Escape sequence state machine; classifies each byte as text, erase or drop.
// ---------------------------------------------------------------------------
module etf_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_stb,
   input  logic [7:0]             in_byte,
   output etf_pkg::parse_act_type act
);
   import etf_pkg::*;

   mode_type mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      act.push  = 1'b0;
      act.erase = 1'b0;
      case (mode_ff)
         MODE_ESC: begin
            if (in_byte == CH_CSI_OPEN) begin
               mode_in = MODE_CSI;
            end else if (in_byte == CH_OSC_OPEN) begin
               mode_in = MODE_OSC;
            end else begin
               mode_in = MODE_TEXT;
            end
         end
         MODE_CSI: begin
            if (in_byte inside {[CSI_FINAL_LO:CSI_FINAL_HI]}) begin
               mode_in = MODE_TEXT;
            end
         end
         MODE_OSC: begin
            if (in_byte == CH_BEL) begin
               mode_in = MODE_TEXT;
            end else if (in_byte == CH_ESC) begin
               mode_in = MODE_OSC_ESC;
            end
         end
         MODE_OSC_ESC: begin
            if (in_byte inside {CH_BSL, CH_BEL}) begin
               mode_in = MODE_TEXT;
            end else if (in_byte != CH_ESC) begin
               mode_in = MODE_OSC;
            end
         end
         default: begin
            mode_in = MODE_TEXT;
            if (in_byte == CH_ESC) begin
               mode_in = MODE_ESC;
            end else if (in_byte inside {CH_CR, CH_BEL}) begin
               // discarded
            end else if (in_byte == CH_BS) begin
               act.erase = 1'b1;
            end else begin
               act.push = 1'b1;
            end
         end
      endcase
      if (!byte_stb) begin
         mode_in   = mode_ff;
         act.push  = 1'b0;
         act.erase = 1'b0;
      end
   end

endmodule

### design/etf_text_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// etf_text_ram
// Text buffer: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module etf_text_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/terminal_escape_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// terminal_escape_filter
// Strips terminal escape sequences and buffers the remaining text.
// ---------------------------------------------------------------------------
// A request beat with tuser 0 carries one terminal byte; a backspace in text
// mode with a non-empty buffer holds off the next request while the last
// buffered byte is read back from the text RAM to check for a newline. A
// request beat with tuser 1 drains the buffer: the buffered bytes leave one
// per cycle through the single RAM read port while rsp_tready is held high,
// and an empty buffer gives one beat with byte_valid low. tlast marks the
// final beat of a drain, and overflowed reports bytes dropped on a full
// buffer since the previous drain. req_tready stays low while a drain is
// being read out and while a read result still waits for the output
// register. The parse state carries across drains.
// ---------------------------------------------------------------------------
module terminal_escape_filter #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // last
   output logic [1:0] rsp_tuser    // [0] byte_valid, [1] overflowed
);
   import etf_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int FW = $clog2(BUFFER_DEPTH + 1);

   ctl_state_type state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic          dropped_ff, dropped_in;
   logic          drain_ovf_ff, drain_ovf_in;
   logic          pend_ff, pend_in;
   logic          pend_last_ff, pend_last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          rsp_bv_ff, rsp_bv_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic          req_acc;
   logic          byte_stb;
   parse_act_type act;
   logic          we, re;
   logic [AW-1:0] waddr, raddr;
   logic [7:0]    rdata;
   logic [FW-1:0] fill_dec, idx_inc;
   logic          out_free, capture;

   assign req_tready = (state_ff == ST_IDLE) && !pend_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign byte_stb   = req_acc && (req_tuser == KIND_BYTE);

   etf_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .byte_stb (byte_stb),
      .in_byte  (req_tdata),
      .act      (act)
   );

   etf_text_ram #(
      .DEPTH (BUFFER_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (req_tdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign fill_dec = fill_ff - 1'b1;
   assign idx_inc  = idx_ff + 1'b1;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign capture  = pend_ff && out_free;
   assign waddr    = fill_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      dropped_in   = dropped_ff;
      drain_ovf_in = drain_ovf_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_bv_in    = rsp_bv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      we           = 1'b0;
      re           = 1'b0;
      raddr        = idx_ff[AW-1:0];

      // output register: a waiting read result has priority
      if (capture) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rdata;
         rsp_bv_in    = 1'b1;
         rsp_last_in  = pend_last_ff;
         rsp_ovf_in   = drain_ovf_ff;
         pend_in      = 1'b0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_tuser == KIND_DRAIN)) begin
               drain_ovf_in = dropped_ff;
               dropped_in   = 1'b0;
               idx_in       = '0;
               state_in     = ST_DRAIN;
            end else if (act.push) begin
               if (fill_ff < FW'(BUFFER_DEPTH)) begin
                  we      = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
            end else if (act.erase && (fill_ff != '0)) begin
               re       = 1'b1;
               raddr    = fill_dec[AW-1:0];
               state_in = ST_ERASE;
            end
         end
         ST_ERASE: begin
            if (rdata != CH_LF) begin
               fill_in = fill_dec;
            end
            state_in = ST_IDLE;
         end
         ST_DRAIN: begin
            if (fill_ff == '0) begin
               // empty buffer: one marker beat
               if (out_free && !pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_bv_in    = 1'b0;
                  rsp_last_in  = 1'b1;
                  rsp_ovf_in   = drain_ovf_ff;
                  state_in     = ST_IDLE;
               end
            end else if (!pend_ff || capture) begin
               re           = 1'b1;
               pend_in      = 1'b1;
               pend_last_in = (idx_inc == fill_ff);
               idx_in       = idx_inc;
               if (idx_inc == fill_ff) begin
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         dropped_ff   <= 1'b0;
         drain_ovf_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         dropped_ff   <= dropped_in;
         drain_ovf_ff <= drain_ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff <= pend_last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_bv_ff    <= rsp_bv_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_bv_ff};

endmodule
